@@ rtl/sbb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbb_pkg
// Shared codes and types for the separable box blur block.
// ----------------------------------------------------------------------------
package sbb_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_RADIUS = 15;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_RUN    = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] CSR_RADIUS = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;

   localparam logic KIND_DONE = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

   // per-channel divider request
   typedef struct packed {
      logic        start;
      logic [12:0] red_sum;
      logic [12:0] green_sum;
      logic [12:0] blue_sum;
      logic [7:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic       done;
      logic [7:0] red_q;
      logic [7:0] green_q;
      logic [7:0] blue_q;
   } div_rsp_type;

endpackage

@@ rtl/sbb_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbb_divider
// Restoring divider, three channels in parallel, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbb_divider (
   input  logic                clock,
   input  logic                reset,
   input  sbb_pkg::div_req_type req,
   output sbb_pkg::div_rsp_type rsp
);

   logic [3:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [12:0] rq_ff, gq_ff, bq_ff, rq_in, gq_in, bq_in;
   logic [8:0]  rr_ff, gr_ff, br_ff, rr_in, gr_in, br_in;
   logic [7:0]  dv_ff, dv_in;
   logic [9:0]  rt, gt, bt;

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      rq_in = rq_ff; gq_in = gq_ff; bq_in = bq_ff;
      rr_in = rr_ff; gr_in = gr_ff; br_in = br_ff;
      dv_in = dv_ff;
      rt = {rr_ff, rq_ff[12]} - {2'b0, dv_ff};
      gt = {gr_ff, gq_ff[12]} - {2'b0, dv_ff};
      bt = {br_ff, bq_ff[12]} - {2'b0, dv_ff};
      if (req.start) begin
         busy_in = 1'b1;
         count_in = 4'd0;
         rq_in = req.red_sum; gq_in = req.green_sum; bq_in = req.blue_sum;
         rr_in = 9'd0; gr_in = 9'd0; br_in = 9'd0;
         dv_in = req.divisor;
      end else if (busy_ff) begin
         rr_in = rt[9] ? {rr_ff[7:0], rq_ff[12]} : rt[8:0];
         gr_in = gt[9] ? {gr_ff[7:0], gq_ff[12]} : gt[8:0];
         br_in = bt[9] ? {br_ff[7:0], bq_ff[12]} : bt[8:0];
         rq_in = {rq_ff[11:0], ~rt[9]};
         gq_in = {gq_ff[11:0], ~gt[9]};
         bq_in = {bq_ff[11:0], ~bt[9]};
         count_in = count_ff + 4'd1;
         if (count_ff == 4'd12) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= 4'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rq_ff <= rq_in; gq_ff <= gq_in; bq_ff <= bq_in;
      rr_ff <= rr_in; gr_ff <= gr_in; br_ff <= br_in;
      dv_ff <= dv_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.red_q   = rq_ff[7:0];
   assign rsp.green_q = gq_ff[7:0];
   assign rsp.blue_q  = bq_ff[7:0];

   a_one_job: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req.start) else $error("divider restarted while busy");
   a_done_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");
   a_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> count_ff <= 4'd12) else $error("divider count overrun");

endmodule

@@ rtl/separable_box_blur_rgb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_box_blur_rgb_top
// Pixel store with a two-pass running box blur.
//
//   channel  ports                                        direction
//   req      req_valid req_stall req_command/index/value  in
//   rsp      rsp_valid rsp_stall rsp_result_kind/pixel_out out
//   csr      csr_valid csr_ready csr_index csr_data        in
//
// Load: one beat per cycle while the output register is empty. Read: a
// registered memory read, then one beat out. Run: per pass, per line, 2r+1
// priming reads, then per pixel two window reads and sum update (not for the
// first pixel of a line), divider start, serial divide, write back; two passes.
// Reset is synchronous; stores are not cleared. rsp_stall holds the output
// register; a new request waits while the output register is full.
// ----------------------------------------------------------------------------
module separable_box_blur_rgb_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_pixel_index,
   input  logic [23:0] req_pixel_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [31:0] rsp_pixel_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data
);

   localparam int MAX_WIDTH  = sbb_pkg::MAX_WIDTH;
   localparam int MAX_HEIGHT = sbb_pkg::MAX_HEIGHT;
   localparam int MAX_RADIUS = sbb_pkg::MAX_RADIUS;
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = $clog2(MAX_WIDTH + 1);
   localparam int YW    = $clog2(MAX_HEIGHT + 1);
   localparam int RW    = $clog2(MAX_RADIUS + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_READ  = 4'd1;
   localparam logic [3:0] S_RDWT  = 4'd2;
   localparam logic [3:0] S_PRIME = 4'd3;
   localparam logic [3:0] S_PRWT  = 4'd4;
   localparam logic [3:0] S_ADD   = 4'd5;
   localparam logic [3:0] S_SUB   = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_WAIT  = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   logic [31:0] img_mem [DEPTH];
   logic [23:0] row_mem [DEPTH];
   logic [31:0] img_q;
   logic [23:0] row_q;
   logic [AW-1:0] img_ra, row_ra, img_wa, row_wa;
   logic        img_we, row_we;
   logic [31:0] img_wd;
   logic [23:0] row_wd;

   always_ff @(posedge clock) begin
      if (img_we) img_mem[img_wa] <= img_wd;
      img_q <= img_mem[img_ra];
   end
   always_ff @(posedge clock) begin
      if (row_we) row_mem[row_wa] <= row_wd;
      row_q <= row_mem[row_ra];
   end

   logic [3:0]    radius_ff;
   logic [8:0]    width_ff, height_ff;
   logic [3:0]    state_ff, state_in;
   logic          pass_ff, pass_in;
   logic [YW-1:0] line_ff, line_in;
   logic [XW-1:0] pos_ff, pos_in;
   logic [RW:0]   cnt_ff, cnt_in;
   logic [12:0]   rs_ff, gs_ff, bs_ff, rs_in, gs_in, bs_in;
   logic [23:0]   old_ff, old_in;
   logic          ov_ff, ov_in;
   logic          ok_ff, ok_in;
   logic [31:0]   od_ff, od_in;
   logic          ob_ff, ob_in;

   logic [RW-1:0] r;
   logic [XW-1:0] w;
   logic [YW-1:0] h;
   logic [XW-1:0] n;
   logic [7:0]    div;
   logic [23:0]   rdpix;
   sbb_pkg::div_req_type dreq;
   sbb_pkg::div_rsp_type drsp;

   assign r = (radius_ff > 4'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_ff);
   assign w = (width_ff == 9'd0) ? XW'(1) :
              ({23'd0, width_ff} > 32'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(width_ff);
   assign h = (height_ff == 9'd0) ? YW'(1) :
              ({23'd0, height_ff} > 32'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(height_ff);
   assign n = pass_ff ? XW'(h) : w;
   assign div = {3'd0, r, 1'b0} + 8'd1;
   assign rdpix = pass_ff ? row_q : img_q[23:0];

   // clamped position within the current line
   function automatic logic [XW-1:0] clampp(input logic signed [XW+RW+1:0] v,
                                             input logic [XW-1:0] lim);
      if (v < 0) return '0;
      if (v >= $signed({{(RW+2){1'b0}}, lim})) return lim - XW'(1);
      return v[XW-1:0];
   endfunction

   function automatic logic [AW-1:0] addr(input logic p, input logic [XW-1:0] pos,
                                          input logic [YW-1:0] ln, input logic [XW-1:0] wi);
      logic [AW+XW:0] a;
      if (p) a = (AW+XW+1)'(pos) * (AW+XW+1)'(wi) + (AW+XW+1)'(ln);
      else   a = (AW+XW+1)'(ln) * (AW+XW+1)'(wi) + (AW+XW+1)'(pos);
      return a[AW-1:0];
   endfunction

   logic signed [XW+RW+1:0] s_pos, s_r, s_cnt;
   logic [XW-1:0] p_add, p_sub;
   assign s_pos = $signed({{(RW+2){1'b0}}, pos_ff});
   assign s_r   = $signed({{(XW+2){1'b0}}, r});
   assign s_cnt = $signed({{(XW+1){1'b0}}, cnt_ff});
   assign p_add = clampp(s_pos + s_r + (XW+RW+2)'(1), n);
   assign p_sub = clampp(s_pos - s_r, n);

   logic [XW-1:0] rd_pos;
   logic [AW-1:0] rd_addr;
   assign rd_addr = addr(pass_ff, rd_pos, line_ff, w);

   logic accept;
   assign req_stall = !(state_ff == S_IDLE) || ov_ff;
   assign accept = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff; pass_in = pass_ff; line_in = line_ff; pos_in = pos_ff;
      cnt_in = cnt_ff; rs_in = rs_ff; gs_in = gs_ff; bs_in = bs_ff; old_in = old_ff;
      ov_in = ov_ff && rsp_stall; ok_in = ok_ff; od_in = od_ff;
      img_we = 1'b0; img_wa = req_pixel_index[AW-1:0];
      img_wd = {8'd0, req_pixel_value};
      row_we = 1'b0; row_wa = rd_addr; row_wd = '0;
      img_ra = req_pixel_index[AW-1:0]; row_ra = rd_addr;
      rd_pos = '0;
      ob_in = ob_ff;
      dreq = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_command)
                  sbb_pkg::CMD_LOAD: begin
                     img_we = ({16'd0, req_pixel_index} < 32'(DEPTH));
                  end
                  sbb_pkg::CMD_READ: begin
                     ob_in = ({16'd0, req_pixel_index} < 32'(DEPTH));
                     state_in = S_RDWT;
                  end
                  sbb_pkg::CMD_RUN: begin
                     if (r == '0) state_in = S_DONE;
                     else begin
                        pass_in = 1'b0; line_in = '0; state_in = S_PRIME;
                        cnt_in = '0; rs_in = '0; gs_in = '0; bs_in = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RDWT: begin
            ov_in = 1'b1; ok_in = sbb_pkg::KIND_READ;
            od_in = ob_ff ? img_q : 32'd0;
            state_in = S_IDLE;
         end
         S_PRIME: begin
            // prime window: positions -r..r
            rd_pos = clampp(s_cnt - s_r, n);
            img_ra = rd_addr; row_ra = rd_addr;
            state_in = S_PRWT;
         end
         S_PRWT: begin
            rs_in = rs_ff + 13'(rdpix[23:16]);
            gs_in = gs_ff + 13'(rdpix[15:8]);
            bs_in = bs_ff + 13'(rdpix[7:0]);
            if (cnt_ff == {r, 1'b0}) begin
               pos_in = '0; state_in = S_DIV;
            end else begin
               cnt_in = cnt_ff + 1'b1; state_in = S_PRIME;
            end
         end
         S_DIV: begin
            dreq.start = 1'b1; dreq.red_sum = rs_ff; dreq.green_sum = gs_ff;
            dreq.blue_sum = bs_ff; dreq.divisor = div;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (drsp.done) begin
               rd_pos = pos_ff;
               if (pass_ff) begin
                  img_we = 1'b1; img_wa = rd_addr;
                  img_wd = {sbb_pkg::ALPHA_OPAQUE, drsp.red_q, drsp.green_q, drsp.blue_q};
               end else begin
                  row_we = 1'b1; row_wa = rd_addr;
                  row_wd = {drsp.red_q, drsp.green_q, drsp.blue_q};
               end
               if (pos_ff == n - XW'(1)) begin
                  cnt_in = '0; rs_in = '0; gs_in = '0; bs_in = '0;
                  if (XW'(line_ff) == (pass_ff ? XW'(w) : XW'(h)) - XW'(1)) begin
                     if (pass_ff) state_in = S_DONE;
                     else begin
                        pass_in = 1'b1; line_in = '0; state_in = S_PRIME;
                     end
                  end else begin
                     line_in = line_ff + 1'b1; state_in = S_PRIME;
                  end
               end else begin
                  state_in = S_SUB;
               end
            end
         end
         S_SUB: begin
            // fetch outgoing pixel
            rd_pos = p_sub; img_ra = rd_addr; row_ra = rd_addr;
            state_in = S_ADD;
         end
         S_ADD: begin
            if (cnt_ff[0] == 1'b0) begin
               old_in = rdpix;
               rd_pos = p_add; img_ra = rd_addr; row_ra = rd_addr;
               cnt_in[0] = 1'b1;
            end else begin
               rs_in = rs_ff - 13'(old_ff[23:16]) + 13'(rdpix[23:16]);
               gs_in = gs_ff - 13'(old_ff[15:8]) + 13'(rdpix[15:8]);
               bs_in = bs_ff - 13'(old_ff[7:0]) + 13'(rdpix[7:0]);
               cnt_in[0] = 1'b0;
               pos_in = pos_ff + 1'b1;
               state_in = S_DIV;
            end
         end
         S_DONE: begin
            ov_in = 1'b1; ok_in = sbb_pkg::KIND_DONE; od_in = 32'd0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   sbb_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ov_ff     <= 1'b0;
         radius_ff <= 4'd1;
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
         if (csr_valid) begin
            case (csr_index)
               sbb_pkg::CSR_RADIUS: radius_ff <= csr_data[3:0];
               sbb_pkg::CSR_WIDTH:  width_ff  <= csr_data;
               sbb_pkg::CSR_HEIGHT: height_ff <= csr_data;
               default: ;
            endcase
         end
      end
      pass_ff <= pass_in; line_ff <= line_in; pos_ff <= pos_in; cnt_ff <= cnt_in;
      rs_ff <= rs_in; gs_ff <= gs_in; bs_ff <= bs_in; old_ff <= old_in;
      ok_ff <= ok_in; od_ff <= od_in; ob_ff <= ob_in;
   end

   assign rsp_valid       = ov_ff;
   assign rsp_result_kind = ok_ff;
   assign rsp_pixel_out   = od_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && rsp_stall |=> ov_ff && $stable(od_ff)) else $error("beat dropped");
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall) else $error("request taken while busy");
   a_read_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RDWT |=> ov_ff && ok_ff == sbb_pkg::KIND_READ)
      else $error("read lost");

endmodule
